@@ rtl/matrix_multiply_core_macros.svh @@
// Assertion macros shared by the matrix multiply RTL.
// Used by mm_ctrl and mm_datapath; expects clk and rst in scope.
`ifndef MATRIX_MULTIPLY_CORE_MACROS_SVH
`define MATRIX_MULTIPLY_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define MM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define MM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/mm_pkg.sv @@
// Package for the matrix multiply core: sizes, codes, element helpers and
// the command/status structs between controller and datapath. No dependencies.
package mm_pkg;

  localparam int MAX_DIM     = 8;
  localparam int ELEM_WIDTH  = 16;
  localparam int VALUE_W     = 16;
  localparam int PROD_WIDTH  = 35;
  localparam int DIM_W       = 4;
  localparam int FIELD_IDX_W = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int OPCODE_W    = 2;

  localparam int IDX_W      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int MEM_DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W     = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int MUL_W      = 2 * ELEM_WIDTH;

  typedef logic [OPCODE_W-1:0]  opcode_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [DIM_W-1:0]     dim_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [FIELD_IDX_W-1:0] field_idx_t;
  typedef logic signed [ELEM_WIDTH-1:0] elem_t;
  typedef logic signed [VALUE_W-1:0]    value_t;
  typedef logic signed [PROD_WIDTH-1:0] prod_t;

  localparam opcode_t OP_LOAD_A  = 2'd0;
  localparam opcode_t OP_LOAD_B  = 2'd1;
  localparam opcode_t OP_COMPUTE = 2'd2;

  localparam cfg_idx_t CFG_ROWS_A    = 2'd0;
  localparam cfg_idx_t CFG_INNER_DIM = 2'd1;
  localparam cfg_idx_t CFG_COLS_B    = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN
  } mm_state_t;

  typedef struct packed {
    logic       wr_a;
    logic       wr_b;
    logic       rd_en;
    addr_t      rd_addr_a;
    addr_t      rd_addr_b;
    logic       acc_clr;
    logic       emit;
    field_idx_t row;
    field_idx_t col;
    logic       last;
  } mm_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } mm_status_t;

  // casts the input word to the element width; both are 16 bits, so the value is unchanged
  function automatic elem_t to_elem(value_t v);
    return ELEM_WIDTH'(v);
  endfunction

  function automatic addr_t elem_addr(field_idx_t r, field_idx_t c);
    return ADDR_W'(int'(r) * MAX_DIM + int'(c));
  endfunction

  function automatic dim_t clamp_dim(dim_t d);
    return (int'(d) > MAX_DIM) ? DIM_W'(MAX_DIM) : d;
  endfunction

endpackage

@@ rtl/mm_in_if.sv @@
// Input channel of the matrix multiply core: load and compute words.
// Depends on mm_pkg.
interface mm_in_if;
  logic                valid;
  logic                ready;
  mm_pkg::opcode_t     opcode;
  mm_pkg::field_idx_t  row;
  mm_pkg::field_idx_t  col;
  mm_pkg::value_t      value;

  modport source (output valid, opcode, row, col, value, input ready);
  modport sink   (input valid, opcode, row, col, value, output ready);
endinterface

@@ rtl/mm_out_if.sv @@
// Result channel of the matrix multiply core: one product element per word.
// Depends on mm_pkg.
interface mm_out_if;
  logic                valid;
  logic                ready;
  mm_pkg::field_idx_t  out_row;
  mm_pkg::field_idx_t  out_col;
  mm_pkg::prod_t       product;
  logic                last;

  modport source (output valid, out_row, out_col, product, last, input ready);
  modport sink   (input valid, out_row, out_col, product, last, output ready);
endinterface

@@ rtl/mm_cfg_if.sv @@
// Configuration write channel of the matrix multiply core.
// Depends on mm_pkg.
interface mm_cfg_if;
  logic              valid;
  logic              ready;
  mm_pkg::cfg_idx_t  index;
  mm_pkg::dim_t      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/matrix_multiply_core.sv @@
// Matrix multiply core, top level: controller plus datapath.
// Depends on mm_pkg, mm_in_if, mm_out_if, mm_cfg_if, mm_ctrl, mm_datapath.
//
// Usage:
//   cfg  : write rows_a (index 0), inner_dim (1), cols_b (2) while idle;
//          values above 8 act as 8. Always ready.
//   req  : opcode 0/1 loads one element of A/B at (row, col); opcode 2 runs
//          C = A * B; opcode 3 is dropped. Unwritten entries read as junk.
//   rsp  : one word per element of C in row-major order, last on the final one.
// Timing:
//   Loads are taken one per cycle while no compute is running. A compute holds
//   req.ready low for its whole walk: for each product element the controller
//   issues one store read per inner step, then waits while the registered read,
//   multiply and accumulate stages drain.
//   The result sits in an output register; a stalled receiver holds the walk
//   at the next element until that word is taken. No result when rows_a or
//   cols_b is 0.
// Reset: rst (sync, high) returns the dimensions to 8 and empties the result
//   register; store contents are not cleared.
module matrix_multiply_core (
  input  logic      clk,
  input  logic      rst,
  mm_in_if.sink     req,
  mm_out_if.source  rsp,
  mm_cfg_if.sink    cfg
);
  import mm_pkg::*;

  mm_cmd_t    cmd;
  mm_status_t sts;

  mm_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cfg (cfg),
    .sts (sts),
    .cmd (cmd)
  );

  mm_datapath u_datapath (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cmd (cmd),
    .sts (sts)
  );

endmodule

@@ rtl/mm_ctrl.sv @@
// Controller of the matrix multiply core: dimension registers, walk counters
// and the state machine. Depends on mm_pkg, mm_in_if, mm_cfg_if and the macros.
`include "matrix_multiply_core_macros.svh"

module mm_ctrl (
  input  logic              clk,
  input  logic              rst,
  mm_in_if.sink             req,
  mm_cfg_if.sink            cfg,
  input  mm_pkg::mm_status_t sts,
  output mm_pkg::mm_cmd_t   cmd
);
  import mm_pkg::*;

  mm_state_t state, state_next;
  idx_t      i, i_next;
  idx_t      j, j_next;
  idx_t      k, k_next;
  dim_t      rows_a, inner_dim, cols_b;

  logic accept;
  logic in_range;
  logic last_i, last_j;

  assign cfg.ready = 1'b1;
  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign in_range  = (int'(req.row) < MAX_DIM) && (int'(req.col) < MAX_DIM);
  assign last_i    = (DIM_W'(i) == rows_a - DIM_W'(1));
  assign last_j    = (DIM_W'(j) == cols_b - DIM_W'(1));

  // dimensions are clamped on write; a value above MAX_DIM acts as MAX_DIM
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a    <= DIM_W'(8);
      inner_dim <= DIM_W'(8);
      cols_b    <= DIM_W'(8);
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_ROWS_A:    rows_a    <= clamp_dim(cfg.data);
        CFG_INNER_DIM: inner_dim <= clamp_dim(cfg.data);
        CFG_COLS_B:    cols_b    <= clamp_dim(cfg.data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      i     <= '0;
      j     <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      i     <= i_next;
      j     <= j_next;
      k     <= k_next;
    end
  end

  always_comb begin
    state_next    = state;
    i_next        = i;
    j_next        = j;
    k_next        = k;
    cmd           = '0;
    cmd.rd_addr_a = elem_addr(FIELD_IDX_W'(i), FIELD_IDX_W'(k));
    cmd.rd_addr_b = elem_addr(FIELD_IDX_W'(k), FIELD_IDX_W'(j));
    cmd.row       = FIELD_IDX_W'(i);
    cmd.col       = FIELD_IDX_W'(j);
    cmd.last      = last_i && last_j;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (req.opcode)
            OP_LOAD_A: cmd.wr_a = in_range;
            OP_LOAD_B: cmd.wr_b = in_range;
            OP_COMPUTE: begin
              cmd.acc_clr = 1'b1;
              i_next      = '0;
              j_next      = '0;
              k_next      = '0;
              if (rows_a != '0 && cols_b != '0) begin
                state_next = ST_MAC;
              end
            end
            default: ;
          endcase
        end
      end
      ST_MAC: begin
        cmd.rd_en = (inner_dim != '0);
        if (inner_dim == '0 || DIM_W'(k) == inner_dim - DIM_W'(1)) begin
          k_next     = '0;
          state_next = ST_DRAIN;
        end else begin
          k_next = k + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        // wait for the MAC pipe to empty and the result register to free up
        if (!sts.pipe_busy && sts.out_free) begin
          cmd.emit    = 1'b1;
          cmd.acc_clr = 1'b1;
          if (last_j) begin
            j_next = '0;
            if (last_i) begin
              state_next = ST_IDLE;
            end else begin
              i_next     = i + IDX_W'(1);
              state_next = ST_MAC;
            end
          end else begin
            j_next     = j + IDX_W'(1);
            state_next = ST_MAC;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `MM_ASSERT_IMP(a_k_in_range, state == ST_MAC && inner_dim != '0, DIM_W'(k) < inner_dim, "inner index past inner_dim")
  `MM_ASSERT_NXT(a_last_ends, cmd.emit && cmd.last, state == ST_IDLE, "walk continued after last element")
  `MM_ASSERT_IMP(a_rd_only_mac, cmd.rd_en, state == ST_MAC && !cmd.emit, "store read outside the MAC walk")

endmodule

@@ rtl/mm_datapath.sv @@
// Datapath of the matrix multiply core: A and B stores, registered multiply,
// accumulator and result register. Depends on mm_pkg, mm_in_if, mm_out_if, macros.
`include "matrix_multiply_core_macros.svh"

module mm_datapath (
  input  logic               clk,
  input  logic               rst,
  mm_in_if.sink              req,
  mm_out_if.source           rsp,
  input  mm_pkg::mm_cmd_t    cmd,
  output mm_pkg::mm_status_t sts
);
  import mm_pkg::*;

  elem_t store_a [MEM_DEPTH];
  elem_t store_b [MEM_DEPTH];

  elem_t                   rd_a, rd_b;
  logic                    v1, v2;
  logic signed [MUL_W-1:0] mul;
  prod_t                   acc;

  logic       out_valid;
  field_idx_t out_row, out_col;
  prod_t      out_product;
  logic       out_last;

  addr_t wr_addr;
  elem_t wr_data;

  assign wr_addr = elem_addr(req.row, req.col);
  assign wr_data = to_elem(req.value);

  always_ff @(posedge clk) begin
    if (cmd.wr_a) begin
      store_a[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_a <= store_a[cmd.rd_addr_a];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_b) begin
      store_b[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_b <= store_b[cmd.rd_addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.rd_en;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      mul <= rd_a * rd_b;
    end
  end

  // sum wraps at the result width, same as the masked sum
  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + PROD_WIDTH'(mul);
    end
  end

  assign sts.pipe_busy = v1 || v2;
  assign sts.out_free  = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_row     <= cmd.row;
      out_col     <= cmd.col;
      out_product <= acc;
      out_last    <= cmd.last;
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.out_row = out_row;
  assign rsp.out_col = out_col;
  assign rsp.product = out_product;
  assign rsp.last    = out_last;

  `MM_ASSERT_IMP(a_no_overwrite, cmd.emit, !out_valid || rsp.ready, "result word overwritten")
  `MM_ASSERT_IMP(a_emit_pipe_empty, cmd.emit, !v1 && !v2 && !cmd.rd_en, "emit with MAC in flight")
  `MM_ASSERT_IMP(a_rose_from_emit, $rose(out_valid), $past(cmd.emit), "result valid without emit")

endmodule

@@ dv/matrix_multiply_core_tb.sv @@
// Self-checking testbench for matrix_multiply_core: loads A and B, runs computes under
// several dimension settings and checks every product element against its own predictor.
// Depends on mm_pkg, mm_in_if, mm_out_if, mm_cfg_if and the core RTL.
module matrix_multiply_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mm_pkg::*;

  localparam int      CLK_PERIOD    = 20;
  localparam int      RESET_CYCLES  = 11;
  localparam int      SETTLE_CYCLES = 24;
  localparam int      RANDOM_WORDS  = 260;
  localparam longint  CYCLE_LIMIT   = 1_000_000;
  localparam opcode_t OP_UNUSED     = 2'd3;
  localparam value_t  VAL_MIN       = 16'sh8000;
  localparam value_t  VAL_MAX       = 16'sh7FFF;

  typedef struct packed {
    opcode_t    opcode;
    field_idx_t row;
    field_idx_t col;
    value_t     value;
  } mm_word_t;

  typedef struct packed {
    field_idx_t row;
    field_idx_t col;
    prod_t      product;
    logic       last;
  } prod_elem_t;

  logic clk;
  logic rst;

  mm_in_if  req ();
  mm_out_if rsp ();
  mm_cfg_if cfg ();

  matrix_multiply_core DUT (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  mm_word_t   words_to_send[$];
  prod_elem_t pending_products[$];

  // predictor state: operand stores updated at each accepted word, dimensions at each register write
  elem_t a_mem[MEM_DEPTH];
  elem_t b_mem[MEM_DEPTH];
  dim_t  dim_rows  = 4'd8;
  dim_t  dim_inner = 4'd8;
  dim_t  dim_cols  = 4'd8;

  // generator view: which entries have been queued for writing so far, and the current dimensions
  bit    a_loaded[MEM_DEPTH];
  bit    b_loaded[MEM_DEPTH];
  dim_t  gen_rows, gen_inner, gen_cols;

  int send_idle_pct = 0;
  int take_idle_pct = 0;
  int mismatches    = 0;
  int loads_taken   = 0;
  int computes_taken = 0;
  int ignored_taken = 0;
  int products_checked = 0;
  int reg_writes    = 0;
  int random_count  = 0;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic int eff_dim(dim_t d);
    return (int'(d) > MAX_DIM) ? MAX_DIM : int'(d);
  endfunction

  task automatic flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= 40) $display("%0t ns mismatch: %s", $realtime, msg);
  endtask

  function automatic void predict_products(mm_word_t w);
    int         nr, nk, nc, addr;
    longint     sum;
    prod_elem_t e;
    addr = int'(w.row) * MAX_DIM + int'(w.col);
    case (w.opcode)
      OP_LOAD_A: begin
        loads_taken++;
        if (int'(w.row) < MAX_DIM && int'(w.col) < MAX_DIM) a_mem[addr] = elem_t'(w.value);
      end
      OP_LOAD_B: begin
        loads_taken++;
        if (int'(w.row) < MAX_DIM && int'(w.col) < MAX_DIM) b_mem[addr] = elem_t'(w.value);
      end
      OP_COMPUTE: begin
        computes_taken++;
        nr = eff_dim(dim_rows);
        nk = eff_dim(dim_inner);
        nc = eff_dim(dim_cols);
        for (int i = 0; i < nr; i++) begin
          for (int j = 0; j < nc; j++) begin
            sum = 0;
            for (int k = 0; k < nk; k++)
              sum += longint'(a_mem[i * MAX_DIM + k]) * longint'(b_mem[k * MAX_DIM + j]);
            e.row     = field_idx_t'(i);
            e.col     = field_idx_t'(j);
            e.product = prod_t'(sum);
            e.last    = (i == nr - 1) && (j == nc - 1);
            pending_products.push_back(e);
          end
        end
      end
      default: ignored_taken++;
    endcase
  endfunction

  // request driver
  always @(posedge clk) begin : feed_words
    mm_word_t nxt;
    if (rst) begin
      req.valid <= 1'b0;
    end else begin
      if (req.valid && req.ready) predict_products(mm_word_t'({req.opcode, req.row, req.col,
                                                               req.value}));
      if (!req.valid || req.ready) begin
        if (words_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = words_to_send.pop_front();
          req.valid  <= 1'b1;
          req.opcode <= nxt.opcode;
          req.row    <= nxt.row;
          req.col    <= nxt.col;
          req.value  <= nxt.value;
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and checker
  always @(posedge clk) begin : check_products
    prod_elem_t want;
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        products_checked++;
        if (pending_products.size() == 0) begin
          flag_mismatch($sformatf("unexpected element (%0d,%0d) product %0d",
                                  rsp.out_row, rsp.out_col, rsp.product));
        end else begin
          want = pending_products.pop_front();
          if (rsp.out_row !== want.row)
            flag_mismatch($sformatf("out_row %0d, want %0d", rsp.out_row, want.row));
          if (rsp.out_col !== want.col)
            flag_mismatch($sformatf("out_col %0d, want %0d", rsp.out_col, want.col));
          if (rsp.product !== want.product)
            flag_mismatch($sformatf("product at (%0d,%0d) is %0d, want %0d",
                                    want.row, want.col, rsp.product, want.product));
          if (rsp.last !== want.last)
            flag_mismatch($sformatf("last at (%0d,%0d) is %b, want %b",
                                    want.row, want.col, rsp.last, want.last));
        end
      end
      rsp.ready <= ($urandom_range(0, 99) >= take_idle_pct);
    end
  end

  // register shadow for the predictor
  always @(posedge clk) begin
    if (!rst && cfg.valid && cfg.ready) begin
      reg_writes++;
      case (cfg.index)
        CFG_ROWS_A:    dim_rows  = cfg.data;
        CFG_INNER_DIM: dim_inner = cfg.data;
        CFG_COLS_B:    dim_cols  = cfg.data;
        default: ;
      endcase
    end
  end

  function automatic value_t pick_value();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 10) return VAL_MIN;
    if (sel < 20) return VAL_MAX;
    if (sel < 25) return value_t'($urandom_range(0, 1) ? -1 : 0);
    return value_t'($urandom_range(0, 65535));
  endfunction

  task automatic queue_word(opcode_t op, int r, int c, value_t v);
    mm_word_t w;
    w.opcode = op;
    w.row    = field_idx_t'(r);
    w.col    = field_idx_t'(c);
    w.value  = v;
    words_to_send.push_back(w);
    if (op == OP_LOAD_A) a_loaded[r * MAX_DIM + c] = 1'b1;
    if (op == OP_LOAD_B) b_loaded[r * MAX_DIM + c] = 1'b1;
    random_count++;
  endtask

  task automatic queue_compute();
    queue_word(OP_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 7), pick_value());
  endtask

  // write every operand entry the next compute reads that has never been loaded
  task automatic fill_operands();
    int nr, nk, nc;
    nr = eff_dim(gen_rows);
    nk = eff_dim(gen_inner);
    nc = eff_dim(gen_cols);
    if (nr == 0 || nc == 0) return;
    for (int k = 0; k < nk; k++) begin
      for (int i = 0; i < nr; i++)
        if (!a_loaded[i * MAX_DIM + k]) queue_word(OP_LOAD_A, i, k, pick_value());
      for (int j = 0; j < nc; j++)
        if (!b_loaded[k * MAX_DIM + j]) queue_word(OP_LOAD_B, k, j, pick_value());
    end
  endtask

  // sampled at negedge so the driver and monitor updates of the same edge are settled
  task automatic wait_idle();
    @(negedge clk);
    while (words_to_send.size() != 0 || req.valid || pending_products.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(cfg_idx_t idx, dim_t d);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= d;
    do @(posedge clk); while (!cfg.ready);
  endtask

  task automatic write_dims(dim_t r, dim_t k, dim_t c);
    wait_idle();
    put_reg(CFG_ROWS_A, r);
    put_reg(CFG_INNER_DIM, k);
    put_reg(CFG_COLS_B, c);
    cfg.valid <= 1'b0;
    gen_rows  = r;
    gen_inner = k;
    gen_cols  = c;
  endtask

  function automatic dim_t pick_dim();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 6)  return 4'd0;
    if (sel < 12) return dim_t'($urandom_range(9, 15));
    if (sel < 20) return dim_t'($urandom_range(5, 8));
    return dim_t'($urandom_range(1, 4));
  endfunction

  initial begin
    int nr, nk, nc, r, c;
    rst        = 1'b1;
    req.valid  = 1'b0;
    req.opcode = OP_LOAD_A;
    req.row    = '0;
    req.col    = '0;
    req.value  = '0;
    rsp.ready  = 1'b0;
    cfg.valid  = 1'b0;
    cfg.index  = CFG_ROWS_A;
    cfg.data   = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // full-length dot products at both extremes: column 0 is the largest sum,
    // column 1 the most negative one
    write_dims(4'd1, 4'd8, 4'd2);
    for (int k = 0; k < MAX_DIM; k++) begin
      queue_word(OP_LOAD_A, 0, k, VAL_MIN);
      queue_word(OP_LOAD_B, k, 0, VAL_MIN);
      queue_word(OP_LOAD_B, k, 1, VAL_MAX);
    end
    queue_word(OP_UNUSED, 7, 7, value_t'(-1));
    queue_compute();
    // zero inner dimension gives all-zero products; zero rows or cols gives nothing
    write_dims(4'd2, 4'd0, 4'd3);
    queue_compute();
    write_dims(4'd0, 4'd15, 4'd5);
    queue_compute();
    write_dims(4'd3, 4'd1, 4'd0);
    queue_compute();

    while (random_count < RANDOM_WORDS) begin
      if (random_count < RANDOM_WORDS / 3) begin
        send_idle_pct = 11;
        take_idle_pct = 72;
      end else if (random_count < 2 * RANDOM_WORDS / 3) begin
        send_idle_pct = 72;
        take_idle_pct = 11;
      end else begin
        send_idle_pct = 0;
        take_idle_pct = 0;
      end
      write_dims(pick_dim(), pick_dim(), pick_dim());
      nr = eff_dim(gen_rows);
      nk = eff_dim(gen_inner);
      nc = eff_dim(gen_cols);
      repeat ($urandom_range(1, 3)) begin
        repeat ($urandom_range(0, 5)) begin
          r = $urandom_range(0, 7);
          c = $urandom_range(0, 7);
          if ($urandom_range(0, 9) == 0) begin
            queue_word(OP_UNUSED, r, c, pick_value());
          end else if ($urandom_range(0, 1) == 0) begin
            // half of the time, rewrite an operand inside the current A when there is one
            if (nr > 0 && nk > 0 && $urandom_range(0, 1)) begin
              r = r % nr;
              c = c % nk;
            end
            queue_word(OP_LOAD_A, r, c, pick_value());
          end else begin
            if (nk > 0 && nc > 0 && $urandom_range(0, 1)) begin
              r = r % nk;
              c = c % nc;
            end
            queue_word(OP_LOAD_B, r, c, pick_value());
          end
        end
        fill_operands();
        queue_compute();
      end
    end

    wait_idle();
    if (pending_products.size() != 0)
      flag_mismatch($sformatf("%0d product elements never arrived", pending_products.size()));
    $display("covered %0d loads, %0d computes, %0d ignored words, %0d register writes",
             loads_taken, computes_taken, ignored_taken, reg_writes);
    $display("checked %0d product elements, %0d mismatches", products_checked, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #(CYCLE_LIMIT * CLK_PERIOD);
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("status: fail");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/mm_pkg.sv
rtl/mm_in_if.sv
rtl/mm_out_if.sv
rtl/mm_cfg_if.sv
rtl/mm_ctrl.sv
rtl/mm_datapath.sv
rtl/matrix_multiply_core.sv
dv/matrix_multiply_core_tb.sv
